/* hw/rtl/acl_pkg.sv */
// Shared action and status codes and fixed transaction field widths for the access code table.
package acl_pkg;

   localparam int CODE_W  = 32;
   localparam int LEVEL_W = 8;

   typedef enum logic [1:0] {
      ACT_ACTIVATE   = 2'd0,
      ACT_DEACTIVATE = 2'd1,
      ACT_CHECK      = 2'd2,
      ACT_CONSUME    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STS_OK     = 2'd0,
      STS_ABSENT = 2'd1,
      STS_LOW    = 2'd2,
      STS_FULL   = 2'd3
   } status_type;

endpackage

/* hw/rtl/acl_if.sv */
// Request and response channel interfaces of the access code table.
interface acl_req_if;
   import acl_pkg::*;

   logic                valid;
   logic                ready;
   action_type          action;
   logic [CODE_W-1:0]   code;
   logic [LEVEL_W-1:0]  level;

   modport source (output valid, output action, output code, output level, input ready);
   modport sink   (input valid, input action, input code, input level, output ready);
endinterface

interface acl_rsp_if;
   import acl_pkg::*;

   logic       valid;
   logic       ready;
   logic       granted;
   status_type status;

   modport source (output valid, output granted, output status, input ready);
   modport sink   (input valid, input granted, input status, output ready);
endinterface

/* hw/rtl/acl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module acl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/access_code_level_table.sv */
// Access code table: ENTRIES-slot memory of {valid, level, code}, swept once per transaction.
// Flow: the request is captured, then the sweep reads the entry memory one slot a cycle,
//   then the write-back step decides, writes the slot and loads the response register,
//   waiting there while that register is full; only then is a new request accepted.
// Reset: synchronous; afterwards a clearing pass writes every slot empty with req_ch.ready
//   low.
module access_code_level_table #(
   parameter int ENTRIES    = 16,
   parameter int CODE_BITS  = 32,
   parameter int LEVEL_BITS = 8
) (
   input logic       clock,
   input logic       reset,
   acl_req_if.sink   req_ch,
   acl_rsp_if.source rsp_ch
);
   import acl_pkg::*;

   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int WORD_W  = 1 + LEVEL_BITS + CODE_BITS;
   localparam int VLD_POS = WORD_W - 1;
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(ENTRIES - 1);
   localparam logic [CNT_W-1:0] END_CNT  = CNT_W'(ENTRIES);

   // one-hot sequencer
   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,   // post-reset sweep marking every slot empty
      ST_IDLE  = 4'b0010,   // waiting for a request transaction
      ST_SCAN  = 4'b0100,   // reading every slot, one per cycle
      ST_UPD   = 4'b1000    // decide, write back, load the response
   } state_type;

   state_type             state_ff,    state_in;
   logic [CNT_W-1:0]      cnt_ff,      cnt_in;
   logic                  chk_vld_ff,  chk_vld_in;
   logic [IDX_W-1:0]      chk_idx_ff,  chk_idx_in;

   // captured request
   action_type            act_ff,      act_in;
   logic [CODE_BITS-1:0]  key_ff,      key_in;
   logic [LEVEL_BITS-1:0] lvl_ff,      lvl_in;

   // sweep findings
   logic                  hit_ff,      hit_in;
   logic [IDX_W-1:0]      hit_idx_ff,  hit_idx_in;
   logic [LEVEL_BITS-1:0] hit_lvl_ff,  hit_lvl_in;
   logic                  free_ff,     free_in;
   logic [IDX_W-1:0]      free_idx_ff, free_idx_in;

   // response output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  granted_ff,   granted_in;
   status_type            status_ff,    status_in;

   // entry memory port
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [WORD_W-1:0]     wr_data;
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic [WORD_W-1:0]     rd_data;

   // read word fields
   logic                  rd_vld;
   logic [LEVEL_BITS-1:0] rd_lvl;
   logic [CODE_BITS-1:0]  rd_code;

   // outcome of the finished sweep
   logic                  dec_we;
   logic [IDX_W-1:0]      dec_addr;
   logic [WORD_W-1:0]     dec_data;
   logic                  dec_grant;
   status_type            dec_status;
   logic                  rsp_load;

   assign rd_vld  = rd_data[VLD_POS];
   assign rd_lvl  = rd_data[VLD_POS-1:CODE_BITS];
   assign rd_code = rd_data[CODE_BITS-1:0];

   acl_ram #(
      .WIDTH (WORD_W),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Decision from the sweep results. Deactivate and consume write an empty word.
   always_comb begin
      dec_we     = 1'b0;
      dec_addr   = hit_idx_ff;
      dec_data   = '0;
      dec_grant  = 1'b0;
      dec_status = STS_OK;
      unique case (act_ff)
         ACT_ACTIVATE: begin
            dec_data = {1'b1, lvl_ff, key_ff};
            if (hit_ff) begin
               dec_we = 1'b1;                 // level overwritten in place
            end else if (free_ff) begin
               dec_we   = 1'b1;               // lowest free slot
               dec_addr = free_idx_ff;
            end else begin
               dec_status = STS_FULL;
            end
         end
         ACT_DEACTIVATE: begin
            if (hit_ff) begin
               dec_we = 1'b1;
            end else begin
               dec_status = STS_ABSENT;
            end
         end
         ACT_CHECK, ACT_CONSUME: begin
            if (!hit_ff) begin
               dec_status = STS_ABSENT;
            end else if (hit_lvl_ff < lvl_ff) begin
               dec_status = STS_LOW;
            end else begin
               dec_grant = 1'b1;
               dec_we    = (act_ff == ACT_CONSUME);
            end
         end
         default: begin
            dec_status = STS_OK;
         end
      endcase
   end

   // Response register takes a new result when empty or being drained.
   assign rsp_load     = (state_ff == ST_UPD) && (!rsp_valid_ff || rsp_ch.ready);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ch.ready);
   assign granted_in   = rsp_load ? dec_grant  : granted_ff;
   assign status_in    = rsp_load ? dec_status : status_ff;

   assign req_ch.ready   = (state_ff == ST_IDLE);
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.granted = granted_ff;
   assign rsp_ch.status  = status_ff;

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      chk_vld_in  = 1'b0;
      chk_idx_in  = cnt_ff[IDX_W-1:0];
      act_in      = act_ff;
      key_in      = key_ff;
      lvl_in      = lvl_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_lvl_in  = hit_lvl_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      wr_en       = 1'b0;
      wr_addr     = dec_addr;
      wr_data     = dec_data;
      rd_en       = 1'b0;
      rd_addr     = cnt_ff[IDX_W-1:0];

      // examine the word read in the previous cycle; first match and first hole win
      if (chk_vld_ff) begin
         if (rd_vld && (rd_code == key_ff) && !hit_ff) begin
            hit_in     = 1'b1;
            hit_idx_in = chk_idx_ff;
            hit_lvl_in = rd_lvl;
         end
         if (!rd_vld && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = chk_idx_ff;
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff[IDX_W-1:0];
            wr_data = '0;
            if (cnt_ff == LAST_CNT) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               act_in   = req_ch.action;
               key_in   = CODE_BITS'(req_ch.code);
               lvl_in   = LEVEL_BITS'(req_ch.level);
               hit_in   = 1'b0;
               free_in  = 1'b0;
               cnt_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff != END_CNT) begin
               rd_en      = 1'b1;
               chk_vld_in = 1'b1;
               cnt_in     = cnt_ff + 1'b1;
            end else begin
               state_in = ST_UPD;             // last word is examined this cycle
            end
         end
         ST_UPD: begin
            if (rsp_load) begin
               wr_en    = dec_we;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff  <= chk_idx_in;
      act_ff      <= act_in;
      key_ff      <= key_in;
      lvl_ff      <= lvl_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_lvl_ff  <= hit_lvl_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      granted_ff  <= granted_in;
      status_ff   <= status_in;
   end

   // memory is written only by the clearing pass or the write-back step
   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_CLEAR || state_ff == ST_UPD))
      else $error("entry write outside clear or write-back");

   // the sweep has covered every slot before a decision is taken
   a_sweep_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD) |-> (cnt_ff == END_CNT && !chk_vld_ff))
      else $error("decision before sweep completed");

   // a new response only appears out of the write-back step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_UPD))
      else $error("response raised outside write-back");

   // a grant always carries the ok status
   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && granted_ff) |-> (status_ff == STS_OK))
      else $error("grant with failing status");

   // reset always restarts the clearing pass
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (state_ff == ST_CLEAR && !rsp_valid_ff))
      else $error("reset did not restart clearing");

endmodule
